>>> src/btra_pkg.sv
package btra_pkg;

  // value width and digit store geometry
  localparam int VALUE_BITS  = 64;
  localparam int DIGIT_DEPTH = VALUE_BITS;
  localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
  localparam int COUNT_W     = $clog2(DIGIT_DEPTH + 1);
  localparam int BIT_CNT_W   = $clog2(VALUE_BITS);

  // radix limits and character codes
  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DIGIT_TEN = 6'd10;
  localparam logic [6:0] CHAR_ZERO = 7'd48;
  localparam logic [6:0] CHAR_A    = 7'd65;

  typedef struct packed {
    logic [63:0] value;
    logic [5:0]  radix;
  } in_t;

  typedef struct packed {
    logic [6:0] ascii_char;
    logic       last;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_READ,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic read_digit;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic bit_last;
    logic div_done;
    logic emit_last;
    logic out_free;
  } status_t;

  // remainder to ascii digit or uppercase letter
  function automatic logic [6:0] digit_char(input logic [5:0] d);
    logic [6:0] c;
    if (d >= DIGIT_TEN) begin
      c = {1'b0, d - DIGIT_TEN} + CHAR_A;
    end else begin
      c = {1'b0, d} + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage

>>> src/btra_ctrl.sv
module btra_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  btra_pkg::status_t  status,
  output btra_pkg::cmd_t     cmd
);
  import btra_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.bit_last) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        cmd.store_digit = 1'b1;
        state_next = status.div_done ? ST_READ : ST_DIV;
      end
      ST_READ: begin
        cmd.read_digit = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next = status.emit_last ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/btra_dpath.sv
module btra_dpath (
  input  logic               clk,
  input  logic               rst,
  input  btra_pkg::cmd_t     cmd,
  output btra_pkg::status_t  status,
  input  btra_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output btra_pkg::out_t     out_data
);
  import btra_pkg::*;

  localparam logic [BIT_CNT_W-1:0] BIT_LAST   = BIT_CNT_W'(VALUE_BITS - 1);
  localparam logic [COUNT_W-1:0]   COUNT_FULL = COUNT_W'(DIGIT_DEPTH - 1);

  logic [VALUE_BITS-1:0] quotient;
  logic [5:0]            partial_rem;
  logic [5:0]            radix_sat;
  logic [BIT_CNT_W-1:0]  bit_cnt;
  logic [COUNT_W-1:0]    digit_count;
  logic [COUNT_W-1:0]    emit_idx;
  logic [5:0]            digit_store [DIGIT_DEPTH];
  logic [5:0]            rd_digit;
  out_t                  out_reg;

  logic [6:0]            rem_shift;
  logic                  rem_ge;
  logic [6:0]            rem_sub;
  logic [5:0]            radix_in;
  logic [COUNT_W-1:0]    rd_addr;

  // clamp the incoming radix to the supported range
  always_comb begin
    if (in_data.radix < RADIX_MIN) begin
      radix_in = RADIX_MIN;
    end else if (in_data.radix > RADIX_MAX) begin
      radix_in = RADIX_MAX;
    end else begin
      radix_in = in_data.radix;
    end
  end

  // one restoring division step
  assign rem_shift = {partial_rem, quotient[VALUE_BITS-1]};
  assign rem_ge    = rem_shift >= {1'b0, radix_sat};
  assign rem_sub   = rem_shift - {1'b0, radix_sat};

  // digits come out most significant first
  assign rd_addr = digit_count - 1'b1 - emit_idx;

  assign status.bit_last  = bit_cnt == BIT_LAST;
  assign status.div_done  = (quotient == '0) || (digit_count == COUNT_FULL);
  assign status.emit_last = emit_idx == (digit_count - 1'b1);
  assign status.out_free  = !out_valid || out_ready;

  // divider and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      quotient    <= '0;
      partial_rem <= '0;
      bit_cnt     <= '0;
      digit_count <= '0;
      emit_idx    <= '0;
    end else begin
      if (cmd.load) begin
        quotient    <= in_data.value[VALUE_BITS-1:0];
        radix_sat   <= radix_in;
        partial_rem <= '0;
        bit_cnt     <= '0;
        digit_count <= '0;
      end
      if (cmd.div_step) begin
        quotient    <= {quotient[VALUE_BITS-2:0], rem_ge};
        partial_rem <= rem_ge ? rem_sub[5:0] : rem_shift[5:0];
        bit_cnt     <= bit_cnt + 1'b1;
      end
      if (cmd.store_digit) begin
        digit_count <= digit_count + 1'b1;
        partial_rem <= '0;
        bit_cnt     <= '0;
        emit_idx    <= '0;
      end
      if (cmd.load_out) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  // digit memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (cmd.store_digit) begin
      digit_store[digit_count[ADDR_W-1:0]] <= partial_rem;
    end
    if (cmd.read_digit) begin
      rd_digit <= digit_store[rd_addr[ADDR_W-1:0]];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_reg.ascii_char <= digit_char(rd_digit);
      out_reg.last       <= status.emit_last;
    end
  end

  assign out_data = out_reg;

endmodule

>>> src/binary_to_radix_ascii.sv
// binary to radix ascii converter
// input beat: in_data.value (unsigned) and in_data.radix, taken on in_valid
// and in_ready; a radix below 2 acts as 2, above 36 as 36
// output beats: one ascii character per beat on out_data, most significant
// digit first, digits 0-9 then A-Z; out_data.last marks the final character
// a zero value gives a single '0' beat with last set
// operation: each digit comes from the bit-serial divider, one quotient bit
// per cycle, after which the remainder is stored as the digit; once the last
// digit is stored, each character is read from the digit memory and then
// loaded into the output register once the output slot is free
// one item is converted at a time: in_ready is high only while the block is
// idle; the next item may be taken while the last character still waits
// when out_ready is low the output register holds its beat and the emit
// sequence pauses until the slot frees up
// reset (rst, synchronous) returns the controller to idle and drops out_valid
module binary_to_radix_ascii (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  btra_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output btra_pkg::out_t  out_data
);
  import btra_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencing
  btra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // divider, digit memory and output register
  btra_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> test/binary_to_radix_ascii_tb.sv
module binary_to_radix_ascii_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btra_pkg::*;

  localparam int RANDOM_NUMBERS = 120;
  localparam int QUIET_LIMIT    = 30000;
  localparam int DRAIN_CYCLES   = 300;
  localparam int IDLE_PCT       = 21;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // numbers waiting to be offered, characters waiting to come back
  in_t  numbers_pending[$];
  out_t chars_expected[$];
  out_t char_want;

  int numbers_taken   = 0;
  int chars_checked   = 0;
  int longest_number  = 0;
  int fail_count      = 0;
  int quiet_cycles    = 0;
  logic steady;

  binary_to_radix_ascii u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // no idling on either side for a run of numbers in the middle
  assign steady = (numbers_taken >= 40) && (numbers_taken < 80);

  // expected characters of one number, most significant digit first
  task automatic convert_number(input in_t item);
    logic [63:0] rest;
    logic [5:0]  base;
    logic [5:0]  digit;
    logic [5:0]  digits[$];
    out_t        ch;
    rest = item.value;
    if (VALUE_BITS < 64) rest = rest & ((64'd1 << VALUE_BITS) - 64'd1);
    base = item.radix;
    if (base < RADIX_MIN) base = RADIX_MIN;
    if (base > RADIX_MAX) base = RADIX_MAX;
    // zero still yields a single digit
    do begin
      digits.push_front(6'(rest % base));
      rest = rest / base;
    end while (rest != 64'd0);
    if (digits.size() > longest_number) longest_number = digits.size();
    for (int k = 0; k < digits.size(); k++) begin
      digit = digits[k];
      if (digit > 6'd9) ch.ascii_char = 7'(digit) - 7'd10 + CHAR_A;
      else ch.ascii_char = 7'(digit) + CHAR_ZERO;
      ch.last = (k == digits.size() - 1);
      chars_expected.push_back(ch);
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        convert_number(in_data);
        numbers_taken <= numbers_taken + 1;
      end
      if (numbers_pending.size() != 0 &&
          (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid <= 1'b1;
        in_data  <= numbers_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output monitor and back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (chars_expected.size() == 0) begin
          $error("character beat with nothing expected: ascii_char %0d last %0b",
                 out_data.ascii_char, out_data.last);
          fail_count++;
        end else begin
          char_want = chars_expected.pop_front();
          if (out_data.ascii_char !== char_want.ascii_char) begin
            $error("ascii_char expected %0d actual %0d",
                   char_want.ascii_char, out_data.ascii_char);
            fail_count++;
          end
          if (out_data.last !== char_want.last) begin
            $error("last expected %0b actual %0b", char_want.last, out_data.last);
            fail_count++;
          end
          chars_checked++;
        end
      end
      out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // watchdog: cycles without any beat on either side
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    in_t   item;
    int    bits;
    logic [63:0] mask;

    // directed numbers: zero, full width, digit/letter boundaries, odd radices
    item.value = 64'd0;                   item.radix = 6'd10; numbers_pending.push_back(item);
    item.value = 64'd0;                   item.radix = 6'd2;  numbers_pending.push_back(item);
    item.value = 64'd0;                   item.radix = 6'd36; numbers_pending.push_back(item);
    item.value = '1;                      item.radix = 6'd2;  numbers_pending.push_back(item);
    item.value = '1;                      item.radix = 6'd36; numbers_pending.push_back(item);
    item.value = '1;                      item.radix = 6'd16; numbers_pending.push_back(item);
    item.value = '1;                      item.radix = 6'd10; numbers_pending.push_back(item);
    item.value = '1;                      item.radix = 6'd3;  numbers_pending.push_back(item);
    item.value = 64'h8000_0000_0000_0000; item.radix = 6'd2;  numbers_pending.push_back(item);
    item.value = 64'd1;                   item.radix = 6'd2;  numbers_pending.push_back(item);
    item.value = 64'd9;                   item.radix = 6'd10; numbers_pending.push_back(item);
    item.value = 64'd10;                  item.radix = 6'd11; numbers_pending.push_back(item);
    item.value = 64'd35;                  item.radix = 6'd36; numbers_pending.push_back(item);
    item.value = 64'd36;                  item.radix = 6'd36; numbers_pending.push_back(item);
    item.value = 64'd1295;                item.radix = 6'd36; numbers_pending.push_back(item);
    item.value = 64'hDEAD_BEEF_CAFE_F00D; item.radix = 6'd16; numbers_pending.push_back(item);
    // radix below two acts as binary, above thirty-six as base 36
    item.value = 64'd13;                  item.radix = 6'd0;  numbers_pending.push_back(item);
    item.value = 64'd13;                  item.radix = 6'd1;  numbers_pending.push_back(item);
    item.value = 64'd1295;                item.radix = 6'd37; numbers_pending.push_back(item);
    item.value = 64'hFFFF_FFFF;           item.radix = 6'd63; numbers_pending.push_back(item);
    item.value = 64'h5555_AAAA_5555_AAAA; item.radix = 6'd32; numbers_pending.push_back(item);

    // random numbers of random bit length, mostly legal radices
    for (int n = 0; n < RANDOM_NUMBERS; n++) begin
      bits = $urandom_range(1, 64);
      mask = '1;
      mask = mask >> (64 - bits);
      item.value = {$urandom, $urandom} & mask;
      if ($urandom_range(0, 19) == 0) item.value = 64'd0;
      if ($urandom_range(0, 99) < 85) item.radix = 6'($urandom_range(2, 36));
      else item.radix = 6'($urandom_range(0, 63));
      numbers_pending.push_back(item);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // wait for every number to be taken and every character to return
    @(negedge clk);
    while ((numbers_pending.size() != 0 || in_valid || chars_expected.size() != 0) &&
           quiet_cycles < QUIET_LIMIT)
      @(negedge clk);

    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: %0d characters still outstanding", chars_expected.size());
      $display("== FAIL ==");
    end else begin
      // stray characters after the last number would show up here
      repeat (DRAIN_CYCLES) @(negedge clk);
      $display("converted %0d numbers into %0d checked characters, longest %0d digits",
               numbers_taken, chars_checked, longest_number);
      $display("covered zero, full-width values, radix 2 to 36 and clamped radices");
      if (fail_count == 0) begin
        $display("== PASS ==");
      end else begin
        $display("== FAIL ==");
      end
    end
    $finish;
  end

endmodule
